// ===== hw/rtl/kmpq_pkg.sv =====
// Shared types and constants for the keyed max-priority queue.
// Used by kmpq_store and the keyed_max_priority_queue top level.
package kmpq_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned PrioW = 32;
  localparam int unsigned StatW = 3;
  localparam int unsigned KeyPortW = 16;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_SETPRI  = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_ABSENT = 3'd4
  } status_e;

  // Outcome of a full scan over the store.
  typedef struct packed {
    logic hit;
    logic free_found;
    logic max_found;
  } scan_res_t;

  // Does (pa, ka) order above (pb, kb)?
  function automatic logic above(input logic signed [PrioW-1:0] pa,
                                 input logic [KeyPortW-1:0] ka,
                                 input logic signed [PrioW-1:0] pb,
                                 input logic [KeyPortW-1:0] kb);
    if (pa != pb) begin
      return pa > pb;
    end
    return ka > kb;
  endfunction

endpackage

// ===== hw/rtl/kmpq_store.sv =====
// Entry memories of the queue with a valid bit per slot.
// Depends on kmpq_pkg. Synchronous read: read data and the read valid bit are registered.
module kmpq_store #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [IdxW-1:0]                rd_idx_i,
  output logic [kmpq_pkg::KeyPortW-1:0]  rd_key_o,
  output logic signed [kmpq_pkg::PrioW-1:0] rd_pri_o,
  output logic                           rd_valid_o,
  input  logic                           wr_en_i,
  input  logic [IdxW-1:0]                wr_idx_i,
  input  logic [kmpq_pkg::KeyPortW-1:0]  wr_key_i,
  input  logic signed [kmpq_pkg::PrioW-1:0] wr_pri_i,
  input  logic                           set_valid_i,
  input  logic                           clr_valid_i
);
  import kmpq_pkg::*;

  logic [KeyPortW-1:0]     key_mem [Capacity];
  logic signed [PrioW-1:0] pri_mem [Capacity];
  logic [Capacity-1:0]     valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_idx_i] <= wr_key_i;
      pri_mem[wr_idx_i] <= wr_pri_i;
    end
    rd_key_o <= key_mem[rd_idx_i];
    rd_pri_o <= pri_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (set_valid_i) valid_q[wr_idx_i] <= 1'b1;
      if (clr_valid_i) valid_q[wr_idx_i] <= 1'b0;
      rd_valid_o <= valid_q[rd_idx_i];
    end
  end

endmodule

// ===== hw/rtl/keyed_max_priority_queue.sv =====
// Keyed max-priority queue over one entry memory scanned slot by slot.
// A scan reads one slot a cycle through the single read port, then the S_WRITE
// state writes back and registers the result, and S_OUT raises out_valid.
// The next transaction is taken once the result has left.
// Reset clears all valid bits and the count; memory contents are left alone.
module keyed_max_priority_queue #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned KeyBits = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [kmpq_pkg::FuncW-1:0]         func_i,
  input  logic [kmpq_pkg::KeyPortW-1:0]      key_i,
  input  logic signed [kmpq_pkg::PrioW-1:0]  priority_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kmpq_pkg::KeyPortW-1:0]      out_key_o,
  output logic signed [kmpq_pkg::PrioW-1:0]  out_priority_o,
  output logic [kmpq_pkg::StatW-1:0]         status_o
);
  import kmpq_pkg::*;

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [KeyPortW-1:0] KeyMask =
    (KeyBits >= KeyPortW) ? {KeyPortW{1'b1}} : KeyPortW'((1 << KeyBits) - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [FuncW-1:0]     func_q;
  logic [KeyPortW-1:0]  key_q;
  logic signed [PrioW-1:0] pri_q;
  logic [IdxW:0]        rd_cnt_q;   // next slot to issue, counts to Capacity
  logic [IdxW:0]        chk_cnt_q;  // slot whose data arrives this cycle
  logic                 chk_en_q;
  scan_res_t            res_q;
  logic [IdxW-1:0]      hit_idx_q, free_idx_q, max_idx_q;
  logic [KeyPortW-1:0]  max_key_q;
  logic signed [PrioW-1:0] max_pri_q;
  logic [CntW-1:0]      count_q;

  logic                 out_valid_q;
  logic [KeyPortW-1:0]  out_key_q;
  logic signed [PrioW-1:0] out_pri_q;
  logic [StatW-1:0]     status_q;

  logic [KeyPortW-1:0]  rd_key;
  logic signed [PrioW-1:0] rd_pri;
  logic                 rd_valid;
  logic                 wr_en, set_v, clr_v;
  logic [IdxW-1:0]      wr_idx;
  logic [StatW-1:0]     st;
  logic                 take;

  assign take = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  // Outcome status of the scanned transaction.
  always_comb begin
    st = ST_OK;
    unique case (func_q)
      FUNC_INSERT: begin
        if (res_q.hit) st = ST_DUP;
        else if (!res_q.free_found) st = ST_FULL;
      end
      FUNC_EXTRACT: if (!res_q.max_found) st = ST_EMPTY;
      FUNC_SETPRI:  if (!res_q.hit) st = ST_ABSENT;
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    set_v = 1'b0;
    clr_v = 1'b0;
    wr_idx = hit_idx_q;
    if (state_q == S_WRITE && st == ST_OK) begin
      unique case (func_q)
        FUNC_INSERT: begin
          wr_en = 1'b1; set_v = 1'b1; wr_idx = free_idx_q;
        end
        FUNC_EXTRACT: begin
          clr_v = 1'b1; wr_idx = max_idx_q;
        end
        FUNC_SETPRI: begin
          wr_en = 1'b1; wr_idx = hit_idx_q;
        end
        default: ;
      endcase
    end
  end

  kmpq_store #(.Capacity(Capacity), .IdxW(IdxW)) u_store (
    .clk_i, .rst_ni,
    .rd_idx_i   (rd_cnt_q[IdxW-1:0]),
    .rd_key_o   (rd_key),
    .rd_pri_o   (rd_pri),
    .rd_valid_o (rd_valid),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_key_i   (key_q),
    .wr_pri_i   (pri_q),
    .set_valid_i(set_v),
    .clr_valid_i(clr_v)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take) state_d = S_SCAN;
      S_SCAN:  if (chk_en_q && chk_cnt_q == (IdxW+1)'(Capacity - 1)) state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      chk_cnt_q   <= '0;
      chk_en_q    <= 1'b0;
      res_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (take) begin
        rd_cnt_q <= '0;
        chk_en_q <= 1'b0;
        res_q    <= '0;
      end else if (state_q == S_SCAN) begin
        chk_en_q  <= rd_cnt_q < (IdxW+1)'(Capacity);
        chk_cnt_q <= rd_cnt_q;
        if (rd_cnt_q < (IdxW+1)'(Capacity)) rd_cnt_q <= rd_cnt_q + 1'b1;
        if (chk_en_q) begin
          if (rd_valid && rd_key == key_q && !res_q.hit) res_q.hit <= 1'b1;
          if (!rd_valid && !res_q.free_found) res_q.free_found <= 1'b1;
          if (rd_valid && (!res_q.max_found ||
              above(rd_pri, rd_key, max_pri_q, max_key_q))) res_q.max_found <= 1'b1;
        end
      end
      if (state_q == S_WRITE) begin
        if (set_v) count_q <= count_q + 1'b1;
        if (clr_v) count_q <= count_q - 1'b1;
      end
      if (state_q == S_OUT) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= func_i;
      key_q  <= key_i & KeyMask;
      pri_q  <= priority_req_i;
    end
    if (state_q == S_SCAN && chk_en_q) begin
      if (rd_valid && rd_key == key_q && !res_q.hit) hit_idx_q <= chk_cnt_q[IdxW-1:0];
      if (!rd_valid && !res_q.free_found) free_idx_q <= chk_cnt_q[IdxW-1:0];
      if (rd_valid && (!res_q.max_found ||
          above(rd_pri, rd_key, max_pri_q, max_key_q))) begin
        max_idx_q <= chk_cnt_q[IdxW-1:0];
        max_key_q <= rd_key;
        max_pri_q <= rd_pri;
      end
    end
    if (state_q == S_WRITE) begin
      status_q <= st;
      if (func_q == FUNC_EXTRACT && st == ST_OK) begin
        out_key_q <= max_key_q;
        out_pri_q <= max_pri_q;
      end else begin
        out_key_q <= '0;
        out_pri_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_key_o      = out_key_q;
  assign out_priority_o = out_pri_q;
  assign status_o       = status_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !take) else $error("transaction taken while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity)) else $error("count overflow");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(set_v && clr_v)) else $error("set and clear together");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_q) else $error("result lost");

endmodule

// ===== tb/keyed_max_priority_queue_tb.sv =====
// Self-checking testbench for the keyed max-priority queue.
// Depends on kmpq_pkg and keyed_max_priority_queue; predicts every result in place.
`timescale 1ns / 1ps

module keyed_max_priority_queue_tb;
  import kmpq_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [KeyPortW-1:0]     key;
    logic signed [PrioW-1:0] prio;
    logic [StatW-1:0]        status;
  } qres_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FuncW-1:0] func_i = '0;
  logic [KeyPortW-1:0] key_i = '0;
  logic signed [PrioW-1:0] priority_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KeyPortW-1:0] out_key_o;
  logic signed [PrioW-1:0] out_priority_o;
  logic [StatW-1:0] status_o;

  // Predictor copy of the store.
  logic [KeyPortW-1:0]     slot_key [Depth];
  logic signed [PrioW-1:0] slot_prio [Depth];
  logic                    slot_used [Depth];
  qres_t awaited_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit stall_active = 1'b0;

  keyed_max_priority_queue u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  function automatic int find_key(logic [KeyPortW-1:0] k);
    for (int i = 0; i < Depth; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic qres_t predict_queue(func_e f, logic [KeyPortW-1:0] k,
                                          logic signed [PrioW-1:0] p);
    qres_t r;
    int s;
    r = '{key: '0, prio: '0, status: ST_OK};
    case (f)
      FUNC_INSERT: begin
        if (find_key(k) >= 0) begin
          r.status = ST_DUP;
        end else begin
          s = -1;
          for (int i = Depth - 1; i >= 0; i--) if (!slot_used[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_key[s] = k;
            slot_prio[s] = p;
            slot_used[s] = 1'b1;
          end
        end
      end
      FUNC_EXTRACT: begin
        s = -1;
        for (int i = 0; i < Depth; i++) begin
          if (slot_used[i] && (s < 0 || slot_prio[i] > slot_prio[s] ||
              (slot_prio[i] == slot_prio[s] && slot_key[i] > slot_key[s]))) s = i;
        end
        if (s < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key = slot_key[s];
          r.prio = slot_prio[s];
          slot_used[s] = 1'b0;
        end
      end
      FUNC_SETPRI: begin
        s = find_key(k);
        if (s < 0) r.status = ST_ABSENT;
        else slot_prio[s] = p;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one transaction after a random gap and records its expected result.
  task automatic send_op(func_e f, logic [KeyPortW-1:0] k, logic signed [PrioW-1:0] p);
    int unsigned g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    func_i = f;
    key_i = k;
    priority_req_i = p;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    awaited_q.push_back(predict_queue(f, k, p));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result key=%h", out_key_o);
      end else begin
        qres_t e;
        e = awaited_q.pop_front();
        if (e.key !== out_key_o || e.prio !== out_priority_o || e.status !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected key=%h prio=%h st=%0d, got key=%h prio=%h st=%0d",
                     e.key, e.prio, e.status, out_key_o, out_priority_o, status_o);
        end
      end
    end
  end

  // Receiver back-pressure in runs of random length, mostly short.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_active && $urandom_range(0, 2) == 0) begin
      stall_left = gap_len();
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("keyed_max_priority_queue_tb NOT OK");
      $finish;
    end
  end

  task automatic test_edges();
    send_op(FUNC_EXTRACT, 16'h0, 32'sd0);
    send_op(FUNC_SETPRI, 16'h1234, 32'sd5);
    send_op(FUNC_INSERT, 16'hFFFF, 32'sh7FFFFFFF);
    send_op(FUNC_INSERT, 16'h0000, 32'sh80000000);
    send_op(FUNC_INSERT, 16'hFFFF, 32'sd1);
    send_op(FUNC_INSERT, 16'h5555, 32'sh7FFFFFFF);
    send_op(FUNC_INSERT, 16'hAAAA, -32'sd1);
    send_op(FUNC_SETPRI, 16'h0000, 32'sh7FFFFFFF);
    send_op(FUNC_NONE, 16'hFFFF, -32'sd1);
    repeat (6) send_op(FUNC_EXTRACT, 16'hFFFF, -32'sd1);
  endtask

  task automatic test_full();
    for (int i = 0; i < Depth; i++) send_op(FUNC_INSERT, 16'(i * 977), 32'(i % 3));
    send_op(FUNC_INSERT, 16'hBEEF, 32'sd9);
    send_op(FUNC_INSERT, 16'd977, 32'sd9);
    repeat (Depth + 1) send_op(FUNC_EXTRACT, 16'h0, 32'sd0);
  endtask

  task automatic test_random(int unsigned n);
    func_e f;
    logic [KeyPortW-1:0] k;
    logic signed [PrioW-1:0] p;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      stall_active = (i / 150) % 2 == 1;
      pick = $urandom_range(0, 99);
      f = pick < 45 ? FUNC_INSERT : pick < 75 ? FUNC_EXTRACT : pick < 97 ? FUNC_SETPRI
          : FUNC_NONE;
      // Narrow key and priority pools force duplicates, ties and hits.
      k = $urandom_range(0, 1) ? 16'($urandom_range(0, 47)) : 16'($urandom);
      p = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) - 32'sd3 : 32'($urandom);
      send_op(f, k, p);
    end
    stall_active = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_edges();
    test_full();
    test_random(1000);
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("keyed_max_priority_queue_tb OK");
    end else begin
      $display("keyed_max_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
